/* sv/itar_pkg.sv */
// Shared types, widths and helpers for the integer-to-ASCII radix converter.
// No dependencies; imported by every module of the block.
package itar_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 5;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 8;
   localparam int ADDR_WIDTH  = $clog2(VALUE_WIDTH);
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = RADIX_WIDTH'(16);
   localparam logic [RADIX_WIDTH-1:0] RADIX_DECIMAL = RADIX_WIDTH'(10);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO     = CHAR_WIDTH'(8'h30);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ALPHA    = CHAR_WIDTH'(8'h41);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS    = CHAR_WIDTH'(8'h2D);
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN     = DIGIT_WIDTH'(10);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] number;
      logic [RADIX_WIDTH-1:0]        radix;
   } req_data_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } rsp_data_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [RADIX_WIDTH-1:0] radix;
   } div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [DIGIT_WIDTH-1:0] digit;
      logic                   quotient_zero;
      logic [VALUE_WIDTH-1:0] quotient;
   } div_res_type;

   typedef struct packed {
      logic                   we;
      logic [ADDR_WIDTH-1:0]  addr;
      logic [DIGIT_WIDTH-1:0] digit;
   } store_wr_type;

   typedef struct packed {
      logic                   start;
      logic                   sign;
      logic [COUNT_WIDTH-1:0] count;
   } emit_cmd_type;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_DIVIDE,
      CTRL_EMIT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SIGN,
      EMIT_FETCH,
      EMIT_LOAD
   } emit_state_type;

   function automatic logic [RADIX_WIDTH-1:0] sat_radix(input logic [RADIX_WIDTH-1:0] r);
      logic [RADIX_WIDTH-1:0] s;
      s = r;
      if (r < RADIX_MIN) s = RADIX_MIN;
      if (r > RADIX_MAX) s = RADIX_MAX;
      return s;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d > 4'(9)) c = CHAR_ALPHA + CHAR_WIDTH'(d - DIGIT_TEN);
      else c = CHAR_ZERO + CHAR_WIDTH'(d);
      return c;
   endfunction

endpackage

/* sv/itar_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, remainder one digit.
// Depends on itar_pkg.
module itar_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  itar_pkg::div_cmd_type cmd,
   output itar_pkg::div_res_type res
);
   import itar_pkg::*;

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [RADIX_WIDTH-1:0] trial;
   logic                   fits;

   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign fits  = trial >= radix_ff;

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         quo_in   = cmd.dividend;
         rem_in   = '0;
         radix_in = cmd.radix;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in  = fits ? DIGIT_WIDTH'(trial - radix_ff) : trial[DIGIT_WIDTH-1:0];
         step_in = step_ff + STEP_WIDTH'(1);
         if (step_ff == STEP_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
   end

   assign res.done          = done_ff;
   assign res.digit         = rem_ff;
   assign res.quotient      = quo_ff;
   assign res.quotient_zero = (quo_ff == '0);

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("divider started while busy");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (RADIX_WIDTH'(rem_ff) < radix_ff)) else $error("remainder not below radix");

endmodule

/* sv/itar_emitter.sv */
// Digit store and character emitter: optional sign, then stored digits most significant first.
// Depends on itar_pkg.
module itar_emitter (
   input  logic                   clock,
   input  logic                   reset,
   input  itar_pkg::store_wr_type wr,
   input  itar_pkg::emit_cmd_type cmd,
   output logic                   done,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itar_pkg::rsp_data_type rsp_data
);
   import itar_pkg::*;

   logic [DIGIT_WIDTH-1:0] mem [VALUE_WIDTH];
   logic [DIGIT_WIDTH-1:0] rd_ff;
   logic [ADDR_WIDTH-1:0]  rd_addr;

   emit_state_type         state_ff, state_in;
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic                   valid_ff, valid_in;
   rsp_data_type           data_ff, data_in;
   logic                   out_free;

   assign rd_addr  = ADDR_WIDTH'(idx_ff - COUNT_WIDTH'(1));
   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (wr.we) mem[wr.addr] <= wr.digit;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      done     = 1'b0;
      case (state_ff)
         EMIT_IDLE: begin
            if (cmd.start) begin
               idx_in   = cmd.count;
               state_in = cmd.sign ? EMIT_SIGN : EMIT_FETCH;
            end
         end
         EMIT_SIGN: begin
            if (out_free) begin
               valid_in          = 1'b1;
               data_in.character = CHAR_MINUS;
               data_in.last      = 1'b0;
               state_in          = EMIT_FETCH;
            end
         end
         EMIT_FETCH: state_in = EMIT_LOAD;
         EMIT_LOAD: begin
            if (out_free) begin
               valid_in          = 1'b1;
               data_in.character = digit_char(rd_ff);
               data_in.last      = (idx_ff == COUNT_WIDTH'(1));
               idx_in            = idx_ff - COUNT_WIDTH'(1);
               if (idx_ff == COUNT_WIDTH'(1)) begin
                  state_in = EMIT_IDLE;
                  done     = 1'b1;
               end else begin
                  state_in = EMIT_FETCH;
               end
            end
         end
         default: state_in = EMIT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (state_ff == EMIT_IDLE)) else $error("emit start while busy");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (state_ff == EMIT_IDLE)) else $error("store written during emission");
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EMIT_LOAD) |-> (idx_ff != '0)) else $error("emit with no digits left");

endmodule

/* sv/integer_to_ascii_radix_top.sv */
// Top level: input capture, sign and magnitude, per-digit division sequencing.
// Depends on itar_pkg, itar_divider and itar_emitter.
// Sequencing: each digit takes a full bit-serial division in the serial divider, then
// each digit is emitted by a store read and a load, after a sign if one is needed.
// Throughput: one number at a time; new requests are stalled until emission ends.
// Reset: synchronous, active high; clears control state, digit store is not cleared.
module integer_to_ascii_radix_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  itar_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itar_pkg::rsp_data_type rsp_data
);
   import itar_pkg::*;

   ctrl_state_type         state_ff, state_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                   neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   accept;
   logic                   emit_done;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic [RADIX_WIDTH-1:0] radix_sat;

   div_cmd_type  div_cmd;
   div_res_type  div_res;
   store_wr_type wr;
   emit_cmd_type emit_cmd;

   assign req_stall  = (state_ff != CTRL_IDLE);
   assign accept     = req_valid && !req_stall;
   assign neg        = req_data.number[VALUE_WIDTH-1];
   assign mag        = neg ? (~req_data.number + VALUE_WIDTH'(1)) : req_data.number;
   assign radix_sat  = sat_radix(req_data.radix);
   assign count_next = count_ff + COUNT_WIDTH'(1);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      radix_in         = radix_ff;
      neg_in           = neg_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = div_res.quotient;
      div_cmd.radix    = radix_ff;
      wr.we            = 1'b0;
      wr.addr          = count_ff[ADDR_WIDTH-1:0];
      wr.digit         = div_res.digit;
      emit_cmd.start   = 1'b0;
      emit_cmd.sign    = neg_ff && (radix_ff == RADIX_DECIMAL);
      emit_cmd.count   = count_next;
      case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               radix_in         = radix_sat;
               neg_in           = neg;
               count_in         = '0;
               div_cmd.start    = 1'b1;
               div_cmd.dividend = mag;
               div_cmd.radix    = radix_sat;
               state_in         = CTRL_DIVIDE;
            end
         end
         CTRL_DIVIDE: begin
            if (div_res.done) begin
               wr.we    = 1'b1;
               count_in = count_next;
               if (div_res.quotient_zero || count_next == COUNT_WIDTH'(VALUE_WIDTH)) begin
                  emit_cmd.start = 1'b1;
                  state_in       = CTRL_EMIT;
               end else begin
                  div_cmd.start = 1'b1;
               end
            end
         end
         CTRL_EMIT: begin
            if (emit_done) state_in = CTRL_IDLE;
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         count_ff <= '0;
         neg_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         neg_ff   <= neg_in;
      end
      radix_ff <= radix_in;
   end

   itar_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   itar_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .cmd       (emit_cmd),
      .done      (emit_done),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTRL_DIVIDE) |-> (count_ff < COUNT_WIDTH'(VALUE_WIDTH)))
      else $error("digit count overflow");

endmodule
